// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the resource safety checker RTL.
// Clocked on clk and disabled in rst by the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RSC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define RSC_ASSERT(label, prop, msg)
`define RSC_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ===== rtl/core/rsc_pkg.sv =====
// Shared constants, codes and controller/datapath types of the resource safety checker.
// No dependencies.
package rsc_pkg;

  localparam int MAX_PROCS = 16;
  localparam int MAX_RES   = 8;

  localparam int PIDX_W  = $clog2(MAX_PROCS);
  localparam int RIDX_W  = $clog2(MAX_RES);
  localparam int PCNT_W  = $clog2(MAX_PROCS + 1);
  localparam int RCNT_W  = $clog2(MAX_RES + 1);
  localparam int ENTRIES = MAX_PROCS * MAX_RES;
  localparam int ADDR_W  = PIDX_W + RIDX_W;

  localparam int MODE_W     = 2;
  localparam int PROC_W     = 4;
  localparam int RES_W      = 3;
  localparam int VALUE_W    = 16;
  localparam int KIND_W     = 2;
  localparam int COUNT_W    = 5;
  localparam int WORK_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int PCFG_W     = 5;
  localparam int RCFG_W     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RES_COUNT  = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TOTAL = 2'd0,
    MODE_MAX   = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_START = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SAFE    = 2'd0,
    KIND_DEAD    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_INIT_WAIT,
    ST_VISIT,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_ADD,
    ST_ADD_WAIT,
    ST_EMIT_SAFE,
    ST_EMIT_DEAD,
    ST_EMIT_SUM
  } state_t;

  typedef struct packed {
    logic load;
    logic run_start;
    logic init_step;
    logic visit_prep;
    logic scan_step;
    logic mark_done;
    logic add_step;
    logic visit_end;
    logic visit_fit;
    logic run_end;
    logic emit_safe;
    logic emit_dead;
    logic emit_sum;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic init_last;
    logic j_last;
    logic pos_done;
    logic fits_now;
    logic stop_fit;
    logic stop_nofit;
    logic ndone_zero;
    logic safe_last;
    logic cur_done;
    logic i_last;
  } dp_status_t;

endpackage

// ===== rtl/core/rsc_if.sv =====
// Valid/ready channel interfaces: request items, result items and register writes.
// Depends on rsc_pkg for the field widths.
interface rsc_item_if;
  import rsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [PROC_W-1:0]   process;
  logic [RES_W-1:0]    resource;
  logic [VALUE_W-1:0]  value;
  modport source (output valid, mode, process, resource, value, input ready);
  modport sink   (input valid, mode, process, resource, value, output ready);
endinterface

interface rsc_result_if;
  import rsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PROC_W-1:0]   proc_id;
  logic                all_safe;
  logic [COUNT_W-1:0]  done_count;
  logic                last;
  modport source (output valid, kind, proc_id, all_safe, done_count, last, input ready);
  modport sink   (input valid, kind, proc_id, all_safe, done_count, last, output ready);
endinterface

interface rsc_cfg_if;
  import rsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rsc_ctrl.sv =====
// Sequencer of the safety check: load, work init sweep, round-robin visits, result emission.
// Depends on rsc_pkg and assert_macros.svh; drives rsc_datapath through dp_cmd_t.
`include "assert_macros.svh"

module rsc_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [rsc_pkg::MODE_W-1:0] in_mode,
  output logic                       in_ready,
  input  rsc_pkg::dp_status_t        st,
  output rsc_pkg::dp_cmd_t           cmd
);
  import rsc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (mode_t'(in_mode) == MODE_START) begin
            cmd.run_start = 1'b1;
            state_next    = ST_INIT;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_last) state_next = ST_INIT_WAIT;
      end
      // last column subtraction lands here
      ST_INIT_WAIT: state_next = ST_VISIT;
      ST_VISIT: begin
        if (st.pos_done) begin
          cmd.visit_end = 1'b1;
          if (st.stop_nofit) begin
            cmd.run_end = 1'b1;
            state_next  = ST_EMIT_SAFE;
          end
        end else begin
          cmd.visit_prep = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.j_last) state_next = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        if (st.fits_now) begin
          cmd.mark_done = 1'b1;
          state_next    = ST_ADD;
        end else begin
          cmd.visit_end = 1'b1;
          if (st.stop_nofit) begin
            cmd.run_end = 1'b1;
            state_next  = ST_EMIT_SAFE;
          end else begin
            state_next = ST_VISIT;
          end
        end
      end
      ST_ADD: begin
        cmd.add_step = 1'b1;
        if (st.j_last) state_next = ST_ADD_WAIT;
      end
      ST_ADD_WAIT: begin
        cmd.visit_end = 1'b1;
        cmd.visit_fit = 1'b1;
        if (st.stop_fit) begin
          cmd.run_end = 1'b1;
          state_next  = ST_EMIT_SAFE;
        end else begin
          state_next = ST_VISIT;
        end
      end
      ST_EMIT_SAFE: begin
        if (st.ndone_zero) begin
          state_next = ST_EMIT_DEAD;
        end else if (st.slot_free) begin
          cmd.emit_safe = 1'b1;
          if (st.safe_last) state_next = ST_EMIT_DEAD;
        end
      end
      ST_EMIT_DEAD: begin
        // finished processes are stepped over without using the output slot
        if (st.cur_done || st.slot_free) begin
          cmd.emit_dead = 1'b1;
          if (st.i_last) state_next = ST_EMIT_SUM;
        end
      end
      ST_EMIT_SUM: begin
        if (st.slot_free) begin
          cmd.emit_sum = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `RSC_ASSERT(a_emit_slot, (cmd.emit_safe || cmd.emit_sum) |-> st.slot_free, "emit into busy slot")
  `RSC_ASSERT(a_mark_fits, cmd.mark_done |-> st.fits_now, "finish without fit")
  `RSC_ASSERT(a_stop_ends, (cmd.visit_end && !cmd.visit_fit && st.stop_nofit) |-> cmd.run_end, "stop missed")

endmodule

// ===== rtl/core/rsc_datapath.sv =====
// Tables, work vector, visit counters and output register of the safety check.
// Depends on rsc_pkg and assert_macros.svh; commanded by rsc_ctrl.
`include "assert_macros.svh"

module rsc_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  rsc_pkg::dp_cmd_t               cmd,
  output rsc_pkg::dp_status_t            st,
  input  logic [rsc_pkg::MODE_W-1:0]     in_mode,
  input  logic [rsc_pkg::PROC_W-1:0]     in_process,
  input  logic [rsc_pkg::RES_W-1:0]      in_resource,
  input  logic [rsc_pkg::VALUE_W-1:0]    in_value,
  input  logic                           cfg_we,
  input  logic [rsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsc_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rsc_pkg::kind_t                 out_kind,
  output logic [rsc_pkg::PROC_W-1:0]     out_proc_id,
  output logic                           out_all_safe,
  output logic [rsc_pkg::COUNT_W-1:0]    out_done_count,
  output logic                           out_last
);
  import rsc_pkg::*;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT_FIRST,
    OP_INIT_SUB,
    OP_SCAN,
    OP_ADD
  } op_t;

  logic [PCNT_W-1:0] proc_count;
  logic [RCNT_W-1:0] res_count;
  logic [PCNT_W-1:0] proc_m1;
  logic [RCNT_W-1:0] res_m1;
  logic [PCFG_W-1:0] pc_raw;
  logic [RCFG_W-1:0] rc_raw;

  logic [VALUE_W-1:0] total_units [MAX_RES];
  logic [VALUE_W-1:0] max_mem     [ENTRIES];
  logic [VALUE_W-1:0] alloc_mem   [ENTRIES];
  logic [ENTRIES-1:0] alloc_vld;

  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic               load_ok, we_total, we_max, we_alloc, rd_alloc_en;
  logic [VALUE_W-1:0] max_q, alloc_q;
  logic               alloc_vld_q;
  op_t                op_q;
  logic [RIDX_W-1:0]  j_q;

  logic signed [WORK_W-1:0] work_units [MAX_RES];
  logic signed [WORK_W-1:0] alloc_ext, total_ext, need, work_cur;
  logic [VALUE_W-1:0]       alloc_val;
  logic                     cmp_ok, fits_acc;

  logic [MAX_PROCS-1:0] done_flags;
  logic [PIDX_W-1:0]    finish_order [MAX_PROCS];
  logic [PIDX_W-1:0]    pos, i_cnt;
  logic [RIDX_W-1:0]    j_cnt;
  logic [PCNT_W-1:0]    idle, ndone, emit_k;

  assign proc_m1 = proc_count - PCNT_W'(1);
  assign res_m1  = res_count - RCNT_W'(1);
  assign pc_raw  = cfg_data[PCFG_W-1:0];
  assign rc_raw  = cfg_data[RCFG_W-1:0];

  // register writes, clamped into the supported range
  always_ff @(posedge clk) begin
    if (rst) begin
      proc_count <= PCNT_W'(MAX_PROCS);
      res_count  <= RCNT_W'(MAX_RES);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PROC_COUNT: begin
          if (pc_raw == '0) proc_count <= PCNT_W'(1);
          else if (int'(pc_raw) > MAX_PROCS) proc_count <= PCNT_W'(MAX_PROCS);
          else proc_count <= PCNT_W'(pc_raw);
        end
        CFG_RES_COUNT: begin
          if (rc_raw == '0) res_count <= RCNT_W'(1);
          else if (int'(rc_raw) > MAX_RES) res_count <= RCNT_W'(MAX_RES);
          else res_count <= RCNT_W'(rc_raw);
        end
        default: ;
      endcase
    end
  end

  // table loads
  assign load_ok  = (int'(in_process) < MAX_PROCS) && (int'(in_resource) < MAX_RES);
  assign we_total = cmd.load && (mode_t'(in_mode) == MODE_TOTAL) && (int'(in_resource) < MAX_RES);
  assign we_max   = cmd.load && (mode_t'(in_mode) == MODE_MAX) && load_ok;
  assign we_alloc = cmd.load && (mode_t'(in_mode) == MODE_ALLOC) && load_ok;
  assign wr_addr  = {in_process[PIDX_W-1:0], in_resource[RIDX_W-1:0]};
  assign rd_addr  = cmd.init_step ? {i_cnt, j_cnt} : {pos, j_cnt};
  assign rd_alloc_en = cmd.init_step || cmd.scan_step || cmd.add_step;

  always_ff @(posedge clk) begin
    if (we_total) total_units[in_resource[RIDX_W-1:0]] <= in_value;
  end

  always_ff @(posedge clk) begin
    if (we_max) max_mem[wr_addr] <= in_value;
    if (cmd.scan_step) max_q <= max_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_alloc) alloc_mem[wr_addr] <= in_value;
    if (rd_alloc_en) begin
      alloc_q     <= alloc_mem[rd_addr];
      alloc_vld_q <= alloc_vld[rd_addr];
    end
  end

  // a cleared entry reads as zero; the end of a run clears them all at once
  always_ff @(posedge clk) begin
    if (rst || cmd.run_end) begin
      alloc_vld <= '0;
    end else if (we_alloc) begin
      alloc_vld[wr_addr] <= 1'b1;
    end
  end

  // second stage: acts on the data read in the previous cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= OP_NONE;
    end else if (cmd.init_step) begin
      op_q <= (i_cnt == '0) ? OP_INIT_FIRST : OP_INIT_SUB;
    end else if (cmd.scan_step) begin
      op_q <= OP_SCAN;
    end else if (cmd.add_step) begin
      op_q <= OP_ADD;
    end else begin
      op_q <= OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_alloc_en) j_q <= j_cnt;
  end

  assign alloc_val = alloc_vld_q ? alloc_q : '0;
  assign alloc_ext = $signed({{(WORK_W - VALUE_W){1'b0}}, alloc_val});
  assign total_ext = $signed({{(WORK_W - VALUE_W){1'b0}}, total_units[j_q]});
  assign need      = $signed({{(WORK_W - VALUE_W){1'b0}}, max_q}) - alloc_ext;
  assign work_cur  = work_units[j_q];
  assign cmp_ok    = (need <= work_cur);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MAX_RES; r++) work_units[r] <= '0;
    end else begin
      case (op_q)
        OP_INIT_FIRST: work_units[j_q] <= total_ext - alloc_ext;
        OP_INIT_SUB:   work_units[j_q] <= work_cur - alloc_ext;
        OP_ADD:        work_units[j_q] <= work_cur + alloc_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.visit_prep) begin
      fits_acc <= 1'b1;
    end else if (op_q == OP_SCAN) begin
      fits_acc <= fits_acc && cmp_ok;
    end
  end

  // run counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt      <= '0;
      j_cnt      <= '0;
      pos        <= '0;
      idle       <= '0;
      ndone      <= '0;
      emit_k     <= '0;
      done_flags <= '0;
    end else begin
      if (cmd.run_start) begin
        i_cnt      <= '0;
        j_cnt      <= '0;
        pos        <= '0;
        idle       <= '0;
        ndone      <= '0;
        done_flags <= '0;
      end
      if (cmd.init_step) begin
        if (i_cnt == proc_m1[PIDX_W-1:0]) begin
          i_cnt <= '0;
          j_cnt <= j_cnt + RIDX_W'(1);
        end else begin
          i_cnt <= i_cnt + PIDX_W'(1);
        end
      end
      if (cmd.visit_prep || cmd.mark_done) j_cnt <= '0;
      if (cmd.scan_step || cmd.add_step) j_cnt <= j_cnt + RIDX_W'(1);
      if (cmd.mark_done) begin
        done_flags[pos] <= 1'b1;
        ndone           <= ndone + PCNT_W'(1);
      end
      if (cmd.visit_end) begin
        idle <= cmd.visit_fit ? PCNT_W'(1) : idle + PCNT_W'(1);
        pos  <= (pos == proc_m1[PIDX_W-1:0]) ? '0 : pos + PIDX_W'(1);
      end
      if (cmd.run_end) begin
        emit_k <= '0;
        i_cnt  <= '0;
      end
      if (cmd.emit_safe) emit_k <= emit_k + PCNT_W'(1);
      if (cmd.emit_dead) i_cnt <= i_cnt + PIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_done) finish_order[ndone[PIDX_W-1:0]] <= pos;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_safe || cmd.emit_sum || (cmd.emit_dead && !done_flags[i_cnt])) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_safe) begin
      out_kind       <= KIND_SAFE;
      out_proc_id    <= PROC_W'(finish_order[emit_k[PIDX_W-1:0]]);
      out_all_safe   <= 1'b0;
      out_done_count <= '0;
      out_last       <= 1'b0;
    end else if (cmd.emit_dead && !done_flags[i_cnt]) begin
      out_kind       <= KIND_DEAD;
      out_proc_id    <= PROC_W'(i_cnt);
      out_all_safe   <= 1'b0;
      out_done_count <= '0;
      out_last       <= 1'b0;
    end else if (cmd.emit_sum) begin
      out_kind       <= KIND_SUMMARY;
      out_proc_id    <= '0;
      out_all_safe   <= (ndone == proc_count);
      out_done_count <= COUNT_W'(ndone);
      out_last       <= 1'b1;
    end
  end

  always_comb begin
    st.slot_free  = !out_valid || out_ready;
    st.init_last  = (i_cnt == proc_m1[PIDX_W-1:0]) && (j_cnt == res_m1[RIDX_W-1:0]);
    st.j_last     = (j_cnt == res_m1[RIDX_W-1:0]);
    st.pos_done   = done_flags[pos];
    st.fits_now   = fits_acc && ((op_q != OP_SCAN) || cmp_ok);
    st.stop_fit   = (proc_count == PCNT_W'(1)) || (ndone == proc_count);
    st.stop_nofit = ((idle + PCNT_W'(1)) == proc_count) || (ndone == proc_count);
    st.ndone_zero = (ndone == '0);
    st.safe_last  = ((emit_k + PCNT_W'(1)) == ndone);
    st.cur_done   = done_flags[i_cnt];
    st.i_last     = (i_cnt == proc_m1[PIDX_W-1:0]);
  end

  `RSC_ASSERT(a_mark_pending, cmd.mark_done |-> !done_flags[pos], "process finished twice")
  `RSC_ASSERT(a_sum_count, cmd.emit_sum |-> ($countones(done_flags) == ndone), "done count mismatch")
  `RSC_ASSERT_NEXT(a_alloc_cleared, cmd.run_end, alloc_vld == '0, "allocation not cleared")

endmodule

// ===== rtl/core/resource_safety_checker_unit.sv =====
// Top level of the resource safety checker (banker's safety check).
// Depends on rsc_pkg, rsc_if, rsc_ctrl and rsc_datapath.

// Load requests (total, maximum demand, allocation) are taken one per cycle while no
// check runs. A start request runs the check: an init sweep computes work from the
// totals and the allocation table, then the processes are visited round-robin; a
// pending process whose need fits in work is marked finished and its allocation is
// added back to work, and a finished process is stepped over. Every step is set by the
// single read port of the allocation memory, one entry a cycle. Results then leave
// through an output register at one per cycle while it is drained: finished processes
// in finish order, deadlocked ones ascending, then the summary with last set. New
// requests are taken again once the summary sits in the output register. Allocation
// entries are cleared at the end of each run through per-entry valid bits, so no
// clearing pass is needed after reset.
module resource_safety_checker_unit (
  input  logic         clk,
  input  logic         rst,
  rsc_item_if.sink     item,
  rsc_result_if.source result,
  rsc_cfg_if.sink      cfg
);
  import rsc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;
  kind_t      out_kind;

  assign cfg.ready   = 1'b1;
  assign result.kind = out_kind;

  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_mode  (item.mode),
    .in_ready (item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  rsc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .in_mode        (item.mode),
    .in_process     (item.process),
    .in_resource    (item.resource),
    .in_value       (item.value),
    .cfg_we         (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_kind       (out_kind),
    .out_proc_id    (result.proc_id),
    .out_all_safe   (result.all_safe),
    .out_done_count (result.done_count),
    .out_last       (result.last)
  );

endmodule
